[rtl/cetp_pkg.sv]
// types, character codes and hex helpers for the colour escape text parser
// no dependencies; imported by colour_escape_text_parser
`default_nettype none

package cetp_pkg;

    localparam int MAX_RESULTS = 5;

    localparam logic [7:0]  CHAR_AMP   = 8'h26;
    localparam logic [7:0]  CHAR_C     = 8'h63;
    localparam logic [7:0]  CHAR_R     = 8'h72;
    localparam logic [7:0]  CHAR_SPACE = 8'd32;
    localparam logic [7:0]  CHAR_NBSP  = 8'd160;
    localparam logic [7:0]  RED_BIT    = 8'h80;
    localparam logic [11:0] WHITE      = 12'hFFF;
    localparam logic signed [15:0] ROW_HIDE = -16'sd8;

    typedef struct packed {
        logic [7:0]         char_byte;
        logic               first_byte;
        logic               last_byte;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic [11:0]        start_colour;
        logic               red_text;
    } cetp_in_t;

    typedef struct packed {
        logic [7:0]         glyph;
        logic               glyph_valid;
        logic               visible;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [3:0]         colour_red;
        logic [3:0]         colour_green;
        logic [3:0]         colour_blue;
        logic               end_of_string;
    } cetp_out_t;

    function automatic logic is_hex(input logic [7:0] b);
        logic r;
        r = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66)
            || (b >= 8'h41 && b <= 8'h46);
        return r;
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] v;
        if (b >= 8'h30 && b <= 8'h39)
            v = b - 8'h30;
        else if (b >= 8'h61 && b <= 8'h66)
            v = b - 8'h57;
        else if (b >= 8'h41 && b <= 8'h46)
            v = b - 8'h37;
        else
            v = 8'h00;
        return v[3:0];
    endfunction

endpackage

`default_nettype wire

[rtl/colour_escape_text_parser.sv]
// colour escape text parser: one word in, up to five glyph results out
// an accepted word passes the input register, then the result job registers
// throughput: 1 word per cycle when each word gives at most one result and the
// output does not stall; a word that replays a broken escape holds the input
// until the single result port has drained the per-word glyph list
// reset: asynchronous, pen and row zero, colour white, colour enabled, no escape
// depends on cetp_pkg
`default_nettype none

module colour_escape_text_parser
    import cetp_pkg::*;
#(
    parameter int GLYPH_ADVANCE = 8
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire cetp_in_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output cetp_out_t      out_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic      cfg_data
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_AMP   = 3'd1;
    localparam logic [2:0] PH_C     = 3'd2;
    localparam logic [2:0] PH_HELD1 = 3'd3;
    localparam logic [2:0] PH_HELD2 = 3'd4;

    localparam logic [15:0] ADV = 16'(GLYPH_ADVANCE);

    // configuration and parser state
    logic        colour_en_reg;
    logic [15:0] pen_x_reg, pen_x_next;
    logic [15:0] row_y_reg, row_y_next;
    logic [11:0] colour_reg, colour_next;
    logic        red_reg, red_next;
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  held_reg [2];
    logic [7:0]  held_next [2];

    // input register
    cetp_in_t    in_data_reg;
    logic        in_full_reg;

    // result job: glyph list of one word
    logic [7:0]  job_glyph_reg [MAX_RESULTS];
    logic [2:0]  job_cnt_reg;
    logic [2:0]  job_idx_reg;
    logic        job_active_reg;
    logic        job_marker_reg;
    logic        job_last_reg;
    logic        job_red_reg;
    logic [15:0] job_x_reg;
    logic [15:0] job_y_reg;
    logic [11:0] job_colour_reg;

    // parse logic
    logic [7:0]  b;
    logic [2:0]  phe;
    logic        hex_ok, complete, advance;
    logic [2:0]  n_glyphs, job_n;
    logic [15:0] pen_eff;
    logic [7:0]  slot [MAX_RESULTS];

    logic out_take, job_done, job_free, consume, load_job, in_take;

    always_comb
    begin
        b          = in_data_reg.char_byte;
        pen_eff    = in_data_reg.first_byte ? in_data_reg.start_x : pen_x_reg;
        row_y_next = in_data_reg.first_byte ? in_data_reg.start_y : row_y_reg;
        red_next   = in_data_reg.first_byte ? in_data_reg.red_text : red_reg;
        colour_next = in_data_reg.first_byte ? in_data_reg.start_colour : colour_reg;
        held_next[0] = held_reg[0];
        held_next[1] = held_reg[1];

        if (in_data_reg.first_byte || phase_reg > PH_HELD2)
            phe = PH_IDLE;
        else
            phe = phase_reg;

        hex_ok   = is_hex(b);
        complete = (phe == PH_AMP && b == CHAR_R) || (phe == PH_HELD2 && hex_ok);
        advance  = (phe == PH_IDLE && b == CHAR_AMP) || (phe == PH_AMP && b == CHAR_C)
                   || ((phe == PH_C || phe == PH_HELD1) && hex_ok);

        // broken escape emits held prefix then breaking byte bar a non-final &
        if (complete)
        begin
            n_glyphs   = 3'd0;
            phase_next = PH_IDLE;
            if (colour_en_reg)
            begin
                if (phe == PH_AMP)
                    colour_next = WHITE;
                else
                    colour_next = {hex_val(held_reg[0]), hex_val(held_reg[1]), hex_val(b)};
            end
        end
        else if (advance)
        begin
            n_glyphs   = in_data_reg.last_byte ? phe + 3'd1 : 3'd0;
            phase_next = in_data_reg.last_byte ? PH_IDLE : phe + 3'd1;
            if (phe == PH_C)
                held_next[0] = b;
            if (phe == PH_HELD1)
                held_next[1] = b;
        end
        else if (b == CHAR_AMP && !in_data_reg.last_byte)
        begin
            n_glyphs   = phe;
            phase_next = PH_AMP;
        end
        else
        begin
            n_glyphs   = phe + 3'd1;
            phase_next = PH_IDLE;
        end

        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            if (3'(k) >= phe)
                slot[k] = b;
            else if (k == 0)
                slot[k] = CHAR_AMP;
            else if (k == 1)
                slot[k] = CHAR_C;
            else if (k == 2)
                slot[k] = held_reg[0];
            else
                slot[k] = held_reg[1];
        end

        job_n      = (n_glyphs == 3'd0 && in_data_reg.last_byte) ? 3'd1 : n_glyphs;
        pen_x_next = pen_eff + 16'(16'(n_glyphs) * ADV);
    end

    assign out_take = job_active_reg && !out_stall;
    assign job_done = out_take && (job_idx_reg == job_cnt_reg - 3'd1);
    assign job_free = !job_active_reg || job_done;
    assign consume  = in_full_reg && (job_n == 3'd0 || job_free);
    assign load_job = consume && job_n != 3'd0;
    assign in_stall = in_full_reg && !consume;
    assign in_take  = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colour_en_reg  <= 1'b1;
            pen_x_reg      <= '0;
            row_y_reg      <= '0;
            colour_reg     <= WHITE;
            red_reg        <= 1'b0;
            phase_reg      <= PH_IDLE;
            in_full_reg    <= 1'b0;
            job_active_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                colour_en_reg <= cfg_data;
            if (consume)
            begin
                pen_x_reg  <= pen_x_next;
                row_y_reg  <= row_y_next;
                colour_reg <= colour_next;
                red_reg    <= red_next;
                phase_reg  <= phase_next;
            end
            if (in_take)
                in_full_reg <= 1'b1;
            else if (consume)
                in_full_reg <= 1'b0;
            if (load_job)
                job_active_reg <= 1'b1;
            else if (job_done)
                job_active_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_data_reg <= in_data;
        if (consume)
        begin
            held_reg[0] <= held_next[0];
            held_reg[1] <= held_next[1];
        end
        if (load_job)
        begin
            for (int k = 0; k < MAX_RESULTS; k++)
                job_glyph_reg[k] <= slot[k];
            job_cnt_reg    <= job_n;
            job_idx_reg    <= 3'd0;
            job_marker_reg <= (n_glyphs == 3'd0);
            job_last_reg   <= in_data_reg.last_byte;
            job_red_reg    <= red_next && !colour_en_reg;
            job_x_reg      <= pen_eff;
            job_y_reg      <= row_y_next;
            job_colour_reg <= colour_next;
        end
        else if (out_take && !job_done)
        begin
            job_idx_reg <= job_idx_reg + 3'd1;
            job_x_reg   <= job_x_reg + ADV;
        end
    end

    logic [7:0] glyph_out;

    always_comb
    begin
        glyph_out = job_marker_reg ? 8'h00
                  : (job_glyph_reg[job_idx_reg] | (job_red_reg ? RED_BIT : 8'h00));
        out_data.glyph         = glyph_out;
        out_data.glyph_valid   = !job_marker_reg;
        out_data.visible       = !job_marker_reg && glyph_out != CHAR_SPACE
                                 && glyph_out != CHAR_NBSP
                                 && $signed(job_y_reg) > ROW_HIDE;
        out_data.pos_x         = job_x_reg;
        out_data.pos_y         = job_y_reg;
        out_data.colour_red    = job_colour_reg[11:8];
        out_data.colour_green  = job_colour_reg[7:4];
        out_data.colour_blue   = job_colour_reg[3:0];
        out_data.end_of_string = job_last_reg && (job_idx_reg == job_cnt_reg - 3'd1);
    end

    assign out_valid = job_active_reg;

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        job_active_reg |-> (job_idx_reg < job_cnt_reg && job_cnt_reg <= 3'd5))
        else $error("result index outside glyph list");

    a_marker_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (job_active_reg && job_marker_reg) |-> (job_cnt_reg == 3'd1 && job_last_reg))
        else $error("end marker not a lone final result");

    a_pen_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && !job_done) |=> (job_x_reg == $past(job_x_reg) + ADV))
        else $error("pen did not advance between glyphs of one word");

    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PH_HELD2)
        else $error("escape phase out of range");
`endif

endmodule

`default_nettype wire
